@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold while out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/rrd_pkg.sv @@
// constants, types and helpers for the round-robin ring drain core
`timescale 1ns / 1ps

package rrd_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int RING_DEPTH  = 512;
    localparam int MAX_BURST   = 64;

    localparam int SRC_W       = $clog2(MAX_SOURCES) > 0 ? $clog2(MAX_SOURCES) : 1;
    localparam int SLOT_W      = $clog2(RING_DEPTH);
    localparam int STORE_DEPTH = MAX_SOURCES * RING_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int NSRC_W      = $clog2(MAX_SOURCES + 1);
    localparam int CNT_W       = $clog2(MAX_BURST + 1);

    // fixed field widths of the stream items
    localparam int OP_W        = 2;
    localparam int SOURCE_W    = 4;
    localparam int SLOTF_W     = 9;
    localparam int WORD_W      = 64;
    localparam int MAXC_W      = 7;
    localparam int CFG_W       = 5;

    localparam int SOURCE_LSB  = 0;
    localparam int SLOT_LSB    = SOURCE_LSB + SOURCE_W;
    localparam int WORD_LSB    = SLOT_LSB + SLOTF_W;
    localparam int MAXC_LSB    = WORD_LSB + WORD_W;
    localparam int IN_BITS     = MAXC_LSB + MAXC_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE      = 2'd0,
        OP_READ_ONE   = 2'd1,
        OP_READ_BURST = 2'd2
    } op_t;

    typedef logic [SRC_W-1:0]  ring_idx_t;
    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [ADDR_W-1:0] store_addr_t;

    function automatic store_addr_t ring_addr(input ring_idx_t r, input slot_idx_t s);
        return ADDR_W'(r) * ADDR_W'(RING_DEPTH) + ADDR_W'(s);
    endfunction

endpackage

@@ hdl/rrd_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module rrd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/round_robin_ring_drain_core.sv @@
// top level: per-source trace rings in one ram, drained by fair round-robin reads
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tuser op, tdata source/slot/word/max_count
// m_axis    out  m_axis_tvalid/tready        tdata read_word, tuser found, tlast last
// cfg       in   cfg_valid/cfg_ready         cfg_data sources_in_use
//
// a producer write or an unused op completes in its accept cycle
// read one: accept, then a ram read and a check for each ring probed, then post
// read burst: accept, ram read and check per word taken or empty ring probed, post; count 0 skips the scan
// after reset a clearing pass zeroes every word of the ring ram while s_axis_tready is low
// results leave through an output register; check and finish wait while it is full
`timescale 1ns / 1ps
`include "assert_macros.svh"

module round_robin_ring_drain_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [3:0] source, [12:4] slot, [76:13] word, [83:77] max_count, zero fill above
    input  logic [rrd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] op
    input  logic [rrd_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [63:0] read_word
    output logic [rrd_pkg::WORD_W-1:0]     m_axis_tdata,
    // [0] found
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rrd_pkg::CFG_W-1:0]      cfg_data
);

    import rrd_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    store_addr_t        clr_cnt_reg;
    logic [CFG_W-1:0]   cfg_reg;
    ring_idx_t          single_next_reg;
    ring_idx_t          burst_next_reg;
    slot_idx_t          head_reg [MAX_SOURCES];
    ring_idx_t          cur_reg;
    logic [NSRC_W-1:0]  visited_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic               is_burst_reg;
    logic [WORD_W-1:0]  pend_word_reg;
    logic               pend_valid_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic               out_found_reg;
    logic               out_last_reg;

    logic [SOURCE_W-1:0] in_source;
    logic [SLOTF_W-1:0]  in_slot;
    logic [WORD_W-1:0]   in_word;
    logic [MAXC_W-1:0]   in_max_count;
    logic                in_fire;
    logic                in_range;

    logic [NSRC_W-1:0]  n_active;
    logic [NSRC_W-1:0]  cur_inc;
    ring_idx_t          cur_adv;
    ring_idx_t          single_start;
    ring_idx_t          burst_start;
    logic [CNT_W-1:0]   in_limit;
    slot_idx_t          head_cur;
    slot_idx_t          head_inc;
    logic [WORD_W-1:0]  rd_word;
    logic               word_nz;
    logic               out_free;
    logic               take;
    logic               out_load;
    logic [NSRC_W-1:0]  visited_inc;
    logic [CNT_W-1:0]   cnt_inc;

    logic               ram_we;
    store_addr_t        ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    store_addr_t        ram_raddr;

    assign in_source    = s_axis_tdata[SOURCE_LSB +: SOURCE_W];
    assign in_slot      = s_axis_tdata[SLOT_LSB +: SLOTF_W];
    assign in_word      = s_axis_tdata[WORD_LSB +: WORD_W];
    assign in_max_count = s_axis_tdata[MAXC_LSB +: MAXC_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_range      = (32'(in_source) < MAX_SOURCES) && (32'(in_slot) < RING_DEPTH);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_active = NSRC_W'(1);
        end
        else if (32'(cfg_reg) > MAX_SOURCES)
        begin
            n_active = NSRC_W'(MAX_SOURCES);
        end
        else
        begin
            n_active = NSRC_W'(cfg_reg);
        end
    end

    // next ring in round-robin order, wrapping at the rings in use
    assign cur_inc      = NSRC_W'(cur_reg) + NSRC_W'(1);
    assign cur_adv      = (cur_inc >= n_active) ? '0 : SRC_W'(cur_inc);
    assign single_start = (NSRC_W'(single_next_reg) >= n_active) ? '0 : single_next_reg;
    assign burst_start  = (NSRC_W'(burst_next_reg) >= n_active) ? '0 : burst_next_reg;
    assign in_limit     = (32'(in_max_count) > MAX_BURST) ? CNT_W'(MAX_BURST)
                                                          : CNT_W'(in_max_count);

    assign head_cur    = head_reg[cur_reg];
    assign head_inc    = (32'(head_cur) == RING_DEPTH - 1) ? '0 : head_cur + SLOT_W'(1);
    assign word_nz     = (rd_word != '0);
    assign out_free    = !out_valid_reg || m_axis_tready;
    // a held burst word moves to the output register as the next one is taken, so a take waits for room there
    assign take        = (state_reg == ST_CHECK) && word_nz && (!pend_valid_reg || out_free);
    // output register loads a held word on a take, or the final result
    assign out_load    = (take && pend_valid_reg) || ((state_reg == ST_FINISH) && out_free);
    assign visited_inc = visited_reg + NSRC_W'(1);
    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign ram_raddr   = ring_addr(cur_reg, head_cur);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (in_fire && (s_axis_tuser == OP_WRITE) && in_range)
        begin
            ram_we    = 1'b1;
            ram_waddr = ring_addr(SRC_W'(in_source), SLOT_W'(in_slot));
            ram_wdata = in_word;
        end
        else if (take)
        begin
            ram_we    = 1'b1;
            ram_waddr = ram_raddr;
        end
    end

    rrd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            cfg_reg         <= CFG_W'(MAX_SOURCES);
            single_next_reg <= '0;
            burst_next_reg  <= '0;
            for (int i = 0; i < MAX_SOURCES; i++)
            begin
                head_reg[i] <= '0;
            end
            cur_reg         <= '0;
            visited_reg     <= '0;
            cnt_reg         <= '0;
            limit_reg       <= '0;
            is_burst_reg    <= 1'b0;
            pend_word_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_word_reg    <= '0;
            out_found_reg   <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        visited_reg    <= '0;
                        cnt_reg        <= '0;
                        pend_valid_reg <= 1'b0;
                        unique case (s_axis_tuser)
                            OP_READ_ONE:
                            begin
                                cur_reg         <= single_start;
                                single_next_reg <= single_start;
                                is_burst_reg    <= 1'b0;
                                state_reg       <= ST_READ;
                            end
                            OP_READ_BURST:
                            begin
                                cur_reg        <= burst_start;
                                burst_next_reg <= burst_start;
                                limit_reg      <= in_limit;
                                is_burst_reg   <= 1'b1;
                                state_reg      <= (in_limit == '0) ? ST_FINISH : ST_READ;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end

                ST_CHECK:
                begin
                    if (take)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_word_reg  <= pend_word_reg;
                            out_found_reg <= 1'b1;
                            out_last_reg  <= 1'b0;
                        end
                        pend_word_reg     <= rd_word;
                        pend_valid_reg    <= 1'b1;
                        head_reg[cur_reg] <= head_inc;
                        cnt_reg           <= cnt_inc;
                        if (!is_burst_reg)
                        begin
                            single_next_reg <= cur_adv;
                            state_reg       <= ST_FINISH;
                        end
                        else if (cnt_inc == limit_reg)
                        begin
                            burst_next_reg <= cur_adv;
                            state_reg      <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                    else if (!word_nz)
                    begin
                        // ring empty: move on to the next one
                        cur_reg     <= cur_adv;
                        visited_reg <= visited_inc;
                        if (visited_inc == n_active)
                        begin
                            if (is_burst_reg)
                            begin
                                burst_next_reg <= cur_adv;
                            end
                            else
                            begin
                                single_next_reg <= cur_adv;
                            end
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_word_reg   <= pend_valid_reg ? pend_word_reg : '0;
                        out_found_reg  <= pend_valid_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_CLK(a_burst_below_limit, ((state_reg == ST_CHECK) && is_burst_reg) |-> (cnt_reg < limit_reg), "burst count reached limit inside scan")
    `ASSERT_CLK(a_pend_nonzero, pend_valid_reg |-> (pend_word_reg != '0), "held word is zero")
    `ASSERT_CLK(a_cur_in_range, ((state_reg == ST_READ) || (state_reg == ST_CHECK)) |-> (NSRC_W'(cur_reg) < n_active), "scan ring outside rings in use")
    `ASSERT_CLK(a_clear_done, ((state_reg == ST_CLEAR) && (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))) |=> (state_reg == ST_IDLE), "clearing pass did not end")
    `ASSERT_CLK(a_take_moves_head, take |=> (head_reg[$past(cur_reg)] != $past(head_cur)), "head did not advance after take")

endmodule
